// ===== rtl/rpn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared widths, token codes and controller/datapath interface structs for
// the RPN expression evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

  localparam int STACK_DEPTH_DEF = 8;
  localparam int NUM_REGS_DEF    = 16;

  localparam int DATA_W = 32;
  localparam int REG_W  = 16;
  localparam int FUNC_W = 3;
  localparam int LIT_W  = 31;
  localparam int IDX_W  = 4;
  localparam int OP_W   = 4;

  // Token function codes.
  localparam logic [FUNC_W-1:0] FUNC_PUSH_LIT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_REG = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_OPER     = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_END      = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_INC      = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_DEC      = 3'd5;

  // Binary operator codes.
  localparam logic [OP_W-1:0] OP_ADD = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV = 4'd3;
  localparam logic [OP_W-1:0] OP_EQ  = 4'd4;
  localparam logic [OP_W-1:0] OP_NE  = 4'd5;
  localparam logic [OP_W-1:0] OP_LT  = 4'd6;
  localparam logic [OP_W-1:0] OP_GT  = 4'd7;
  localparam logic [OP_W-1:0] OP_LE  = 4'd8;
  localparam logic [OP_W-1:0] OP_GE  = 4'd9;

  typedef struct packed {
    logic load;
    logic pop;
    logic cap_b;
    logic cap_a;
    logic exec;
    logic div_start;
    logic div_take;
    logic push;
    logic reg_rd;
    logic reg_wr;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              op_valid;
    logic              op_div;
    logic              div_done;
    logic              out_free;
  } sts_t;

endpackage

// ===== rtl/rpn_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rpn_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/rpn_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_div
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module rpn_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rpn_pkg::DATA_W-1:0] dividend,
  input  logic [rpn_pkg::DATA_W-1:0] divisor,
  output logic                      done,
  output logic [rpn_pkg::DATA_W-1:0] quotient,
  output logic                      div_zero
);
  import rpn_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} div_state_t;

  div_state_t        state;
  logic [CNT_W-1:0]  cnt;
  logic              neg;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] den;
  logic [DATA_W:0]   rem_sh;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] rem_next;
  logic [DATA_W-1:0] quo_next;

  always_comb begin
    rem_sh = {rem, quo[DATA_W-1]};
    diff   = rem_sh - {1'b0, den};
    if (!diff[DATA_W]) begin
      rem_next = diff[DATA_W-1:0];
      quo_next = {quo[DATA_W-2:0], 1'b1};
    end else begin
      rem_next = rem_sh[DATA_W-1:0];
      quo_next = {quo[DATA_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            if (divisor == '0) begin
              quotient <= '0;
              div_zero <= 1'b1;
              done     <= 1'b1;
            end else begin
              div_zero <= 1'b0;
              neg      <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
              quo      <= dividend[DATA_W-1] ? -dividend : dividend;
              den      <= divisor[DATA_W-1] ? -divisor : divisor;
              rem      <= '0;
              cnt      <= '0;
              state    <= D_RUN;
            end
          end
        end
        D_RUN: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(DATA_W - 1)) begin
            state <= D_FIX;
          end
        end
        D_FIX: begin
          // Magnitude of the most negative value negates back onto itself.
          quotient <= neg ? -quo : quo;
          done     <= 1'b1;
          state    <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/rpn_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_ctrl
// Token sequencer: steps each request through decode, stack and register
// accesses, execution and result delivery.
// ----------------------------------------------------------------------------
module rpn_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  rpn_pkg::sts_t sts,
  output rpn_pkg::cmd_t cmd
);
  import rpn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_REG_RD, S_REG_WR, S_POP1, S_POP2, S_CAP,
    S_EXEC, S_DIV_GO, S_DIV_WAIT, S_PUSH, S_FINISH
  } state_t;

  state_t state;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (sts.func)
            FUNC_PUSH_LIT:                state <= S_PUSH;
            FUNC_PUSH_REG, FUNC_INC,
            FUNC_DEC:                     state <= S_REG_RD;
            FUNC_OPER, FUNC_END:          state <= S_POP1;
            default:                      state <= S_IDLE;
          endcase
        end
        S_REG_RD: begin
          state <= (sts.func == FUNC_PUSH_REG) ? S_PUSH : S_REG_WR;
        end
        S_REG_WR: state <= S_IDLE;
        S_POP1:   state <= S_POP2;
        S_POP2:   state <= S_CAP;
        S_CAP: begin
          // An end token and an unknown operator both finish the expression.
          if (sts.func == FUNC_END || !sts.op_valid) begin
            state <= S_FINISH;
          end else if (sts.op_div) begin
            state <= S_DIV_GO;
          end else begin
            state <= S_EXEC;
          end
        end
        S_EXEC:   state <= S_PUSH;
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (sts.div_done) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: state <= S_IDLE;
        S_FINISH: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.pop       = (state == S_POP1) || (state == S_POP2);
    cmd.cap_b     = (state == S_POP2);
    cmd.cap_a     = (state == S_CAP);
    cmd.exec      = (state == S_EXEC);
    cmd.div_start = (state == S_DIV_GO);
    cmd.div_take  = (state == S_DIV_WAIT) && sts.div_done;
    cmd.push      = (state == S_PUSH);
    cmd.reg_rd    = (state == S_REG_RD);
    cmd.reg_wr    = (state == S_REG_WR);
    cmd.finish    = (state == S_FINISH) && sts.out_free;
  end

endmodule

// ===== rtl/rpn_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_dpath
// Datapath: token latch, value stack, register file, ALU, divider and the
// result register.
// ----------------------------------------------------------------------------
module rpn_dpath #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
  parameter int NUM_REGS    = rpn_pkg::NUM_REGS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rpn_pkg::cmd_t                    cmd,
  output rpn_pkg::sts_t                    sts,
  input  logic [rpn_pkg::FUNC_W-1:0]        func,
  input  logic [rpn_pkg::LIT_W-1:0]         literal_value,
  input  logic [rpn_pkg::IDX_W-1:0]         reg_index,
  input  logic [rpn_pkg::OP_W-1:0]          op_code,
  input  logic                             store_result,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [rpn_pkg::DATA_W-1:0] value,
  output logic                             overflow_seen,
  output logic                             div_zero_seen
);
  import rpn_pkg::*;

  localparam int SAW    = $clog2(STACK_DEPTH);
  localparam int CW     = $clog2(STACK_DEPTH + 1);
  localparam int RAW    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int RCNT_W = $clog2(NUM_REGS + 1);
  localparam int RCMP_W = (IDX_W > RCNT_W) ? IDX_W : RCNT_W;

  // Latched token.
  logic [FUNC_W-1:0] tok_func;
  logic [LIT_W-1:0]  tok_lit;
  logic [IDX_W-1:0]  tok_idx;
  logic [OP_W-1:0]   tok_op;
  logic              tok_store;

  logic [CW-1:0]     count;
  logic              pop_empty;
  logic              stk_full;
  logic              stk_rd_en;
  logic              stk_wr_en;
  logic [SAW-1:0]    stk_rd_addr;
  logic [SAW-1:0]    stk_wr_addr;
  logic [DATA_W-1:0] stk_rd_data;
  logic [DATA_W-1:0] pop_val;
  logic [DATA_W-1:0] push_data;

  logic signed [DATA_W-1:0] a;
  logic signed [DATA_W-1:0] b;
  logic [DATA_W-1:0]        r;
  logic [DATA_W-1:0]        alu_res;
  logic [DATA_W-1:0]        mul_lo;

  logic              ovf_flag;
  logic              dz_flag;

  logic              div_done;
  logic [DATA_W-1:0] div_q;
  logic              div_dz;

  logic              reg_in_range;
  logic [RAW-1:0]    reg_addr;
  logic [NUM_REGS-1:0] reg_vld;
  logic              reg_ok;
  logic [REG_W-1:0]  reg_rd_data;
  logic [REG_W-1:0]  reg_val;
  logic              reg_wr_en;
  logic [REG_W-1:0]  reg_wr_data;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tok_func  <= func;
      tok_lit   <= literal_value;
      tok_idx   <= reg_index;
      tok_op    <= op_code;
      tok_store <= store_result;
    end
  end

  // ---------------- value stack ----------------
  assign stk_full    = (count == CW'(STACK_DEPTH));
  assign stk_rd_en   = cmd.pop && (count != '0);
  assign stk_rd_addr = SAW'(count - CW'(1));
  assign stk_wr_en   = cmd.push && !stk_full;
  assign stk_wr_addr = SAW'(count);
  assign pop_val     = pop_empty ? '0 : stk_rd_data;

  always_comb begin
    unique case (tok_func)
      FUNC_PUSH_LIT: push_data = {1'b0, tok_lit};
      FUNC_PUSH_REG: push_data = {{(DATA_W - REG_W){1'b0}}, reg_val};
      default:       push_data = r;
    endcase
  end

  rpn_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (push_data),
    .rd_en   (stk_rd_en),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.finish) begin
      count <= '0;
    end else if (stk_rd_en) begin
      count <= count - CW'(1);
    end else if (stk_wr_en) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      pop_empty <= (count == '0);
    end
    if (cmd.cap_b) begin
      b <= pop_val;
    end
    if (cmd.cap_a) begin
      a <= pop_val;
    end
    if (cmd.exec) begin
      r <= alu_res;
    end else if (cmd.div_take) begin
      r <= div_q;
    end
  end

  // ---------------- ALU ----------------
  assign mul_lo = a * b;

  always_comb begin
    unique case (tok_op)
      OP_ADD:  alu_res = a + b;
      OP_SUB:  alu_res = a - b;
      OP_MUL:  alu_res = mul_lo;
      OP_EQ:   alu_res = {{(DATA_W - 1){1'b0}}, (a == b)};
      OP_NE:   alu_res = {{(DATA_W - 1){1'b0}}, (a != b)};
      OP_LT:   alu_res = {{(DATA_W - 1){1'b0}}, (a < b)};
      OP_GT:   alu_res = {{(DATA_W - 1){1'b0}}, (a > b)};
      OP_LE:   alu_res = {{(DATA_W - 1){1'b0}}, (a <= b)};
      OP_GE:   alu_res = {{(DATA_W - 1){1'b0}}, (a >= b)};
      default: alu_res = b;
    endcase
  end

  rpn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (a),
    .divisor  (b),
    .done     (div_done),
    .quotient (div_q),
    .div_zero (div_dz)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ovf_flag <= 1'b0;
      dz_flag  <= 1'b0;
    end else if (cmd.finish) begin
      ovf_flag <= 1'b0;
      dz_flag  <= 1'b0;
    end else begin
      if (cmd.push && stk_full) begin
        ovf_flag <= 1'b1;
      end
      if (cmd.div_take && div_dz) begin
        dz_flag <= 1'b1;
      end
    end
  end

  // ---------------- register file ----------------
  // Entries never written read as zero through their valid bits.
  assign reg_in_range = (RCMP_W'(tok_idx) < RCMP_W'(NUM_REGS));
  assign reg_addr     = RAW'(tok_idx);
  assign reg_val      = reg_ok ? reg_rd_data : '0;
  assign reg_wr_en    = reg_in_range && (cmd.reg_wr || (cmd.finish && tok_store));

  always_comb begin
    if (cmd.finish) begin
      reg_wr_data = b[REG_W-1:0];
    end else if (tok_func == FUNC_INC) begin
      reg_wr_data = reg_val + REG_W'(1);
    end else begin
      reg_wr_data = reg_val - REG_W'(1);
    end
  end

  rpn_ram #(.WIDTH(REG_W), .DEPTH(NUM_REGS)) u_reg_ram (
    .clk     (clk),
    .wr_en   (reg_wr_en),
    .wr_addr (reg_addr),
    .wr_data (reg_wr_data),
    .rd_en   (cmd.reg_rd),
    .rd_addr (reg_addr),
    .rd_data (reg_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_vld <= '0;
    end else if (reg_wr_en) begin
      reg_vld[reg_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reg_rd) begin
      reg_ok <= reg_in_range && reg_vld[reg_addr];
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      value         <= b;
      overflow_seen <= ovf_flag;
      div_zero_seen <= dz_flag;
    end
  end

  always_comb begin
    sts.func     = tok_func;
    sts.op_valid = (tok_op <= OP_GE);
    sts.op_div   = (tok_op == OP_DIV);
    sts.div_done = div_done;
    sts.out_free = !out_valid || !out_stall;
  end

endmodule

// ===== rtl/rpn_expression_evaluator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_expression_evaluator
// Reverse-Polish integer evaluator over a value stack and a register file.
// ----------------------------------------------------------------------------
// Tokens are taken one at a time: in_stall stays high from acceptance until
// the token is complete. An end token or an unknown operator also waits
// for the result register to drain, and a divide waits on the divider,
// which produces one quotient bit per cycle. The result register lets the
// next token be accepted while a result still waits. The stack and
// registers live in RAMs with registered reads; the registers read as zero
// through per-entry valid bits until first written, so no clearing pass
// follows reset.
module rpn_expression_evaluator #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
  parameter int NUM_REGS    = rpn_pkg::NUM_REGS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [rpn_pkg::FUNC_W-1:0]        func,
  input  logic [rpn_pkg::LIT_W-1:0]         literal_value,
  input  logic [rpn_pkg::IDX_W-1:0]         reg_index,
  input  logic [rpn_pkg::OP_W-1:0]          op_code,
  input  logic                             store_result,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [rpn_pkg::DATA_W-1:0] value,
  output logic                             overflow_seen,
  output logic                             div_zero_seen
);
  import rpn_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rpn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rpn_dpath #(.STACK_DEPTH(STACK_DEPTH), .NUM_REGS(NUM_REGS)) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .func          (func),
    .literal_value (literal_value),
    .reg_index     (reg_index),
    .op_code       (op_code),
    .store_result  (store_result),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .value         (value),
    .overflow_seen (overflow_seen),
    .div_zero_seen (div_zero_seen)
  );

  // The sequencer must leave idle once a request is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("token accepted but input not stalled afterwards");

  // At most one load, stack, register, execute, divide or result action per cycle.
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.pop, cmd.exec, cmd.div_start, cmd.div_take,
              cmd.push, cmd.reg_rd, cmd.reg_wr, cmd.finish}))
    else $error("controller issued conflicting commands");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished expression did not produce a result");

  // A delivered result must not be presented again.
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !cmd.finish) |=> !out_valid)
    else $error("result repeated after delivery");

endmodule

// ===== bench/rpn_expression_evaluator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_expression_evaluator_tb
// Self-checking bench for the RPN evaluator. A behavioral calculator in the
// bench tracks the stack, the register file and the per-expression flags,
// and it predicts the result of every end token and unknown operator. Directed tests cover
// arithmetic extremes, comparisons, the empty stack, stack overflow, divide
// by zero, unknown operators and unused function codes. Random expressions
// follow. Requests go in bursts with random gaps, and the result side
// stalls on a changing pattern.
// ----------------------------------------------------------------------------
module rpn_expression_evaluator_tb;
  import rpn_pkg::*;

  localparam int STACK_DEPTH = STACK_DEPTH_DEF;
  localparam int NUM_REGS    = NUM_REGS_DEF;

  localparam logic [FUNC_W-1:0] FUNC_RSVD_A = FUNC_DEC + 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_RSVD_B = '1;
  localparam logic [OP_W-1:0]   OP_UNDEF_LO = OP_GE + 4'd1;
  localparam logic [OP_W-1:0]   OP_UNDEF_HI = '1;
  localparam logic [LIT_W-1:0]  LIT_MAX     = '1;

  localparam int RANDOM_TOKENS = 1200;
  localparam int IDLE_LIMIT    = 4000;
  localparam int DRAIN_CYCLES  = 100;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [LIT_W-1:0]  lit;
    logic [IDX_W-1:0]  idx;
    logic [OP_W-1:0]   op;
    logic              store;
  } token_t;

  typedef struct packed {
    logic [DATA_W-1:0] res_value;
    logic              ovf;
    logic              dz;
  } expr_result_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic [FUNC_W-1:0]         func;
  logic [LIT_W-1:0]          literal_value;
  logic [IDX_W-1:0]          reg_index;
  logic [OP_W-1:0]           op_code;
  logic                      store_result;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [DATA_W-1:0]  value;
  logic                      overflow_seen;
  logic                      div_zero_seen;

  // Behavioral calculator state.
  logic [DATA_W-1:0] calc_stack [STACK_DEPTH];
  int unsigned       calc_depth;
  logic [REG_W-1:0]  calc_regs [NUM_REGS];
  logic              calc_ovf;
  logic              calc_dz;

  expr_result_t pending_results[$];
  int unsigned  mismatch_count;
  int unsigned  burst_left;
  int unsigned  idle_cycles;

  rpn_expression_evaluator #(
    .STACK_DEPTH(STACK_DEPTH),
    .NUM_REGS(NUM_REGS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .func(func),
    .literal_value(literal_value),
    .reg_index(reg_index),
    .op_code(op_code),
    .store_result(store_result),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .value(value),
    .overflow_seen(overflow_seen),
    .div_zero_seen(div_zero_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void push_value(logic [DATA_W-1:0] v);
    if (calc_depth < STACK_DEPTH) begin
      calc_stack[calc_depth] = v;
      calc_depth++;
    end else begin
      calc_ovf = 1'b1;
    end
  endfunction

  function automatic logic [DATA_W-1:0] pop_value();
    if (calc_depth == 0) return '0;
    calc_depth--;
    return calc_stack[calc_depth];
  endfunction

  // Divides magnitudes so that the most negative value over -1 wraps
  // instead of trapping.
  function automatic logic [DATA_W-1:0] signed_quotient(logic [DATA_W-1:0] a,
                                                        logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] mag_a, mag_b, q;
    mag_a = a[DATA_W-1] ? -a : a;
    mag_b = b[DATA_W-1] ? -b : b;
    if (mag_b == '0) begin
      calc_dz = 1'b1;
      return '0;
    end
    q = mag_a / mag_b;
    return (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
  endfunction

  function automatic void evaluate_token(token_t t);
    logic [DATA_W-1:0] a, b, r;
    logic              done;
    done = 1'b0;
    r    = '0;
    case (t.func)
      FUNC_PUSH_LIT: push_value({1'b0, t.lit});
      FUNC_PUSH_REG: push_value((t.idx < NUM_REGS) ? {16'b0, calc_regs[t.idx]} : '0);
      FUNC_OPER: begin
        b = pop_value();
        a = pop_value();
        case (t.op)
          OP_ADD: r = a + b;
          OP_SUB: r = a - b;
          OP_MUL: r = a * b;
          OP_DIV: r = signed_quotient(a, b);
          OP_EQ:  r = {31'b0, a == b};
          OP_NE:  r = {31'b0, a != b};
          OP_LT:  r = {31'b0, $signed(a) < $signed(b)};
          OP_GT:  r = {31'b0, $signed(a) > $signed(b)};
          OP_LE:  r = {31'b0, $signed(a) <= $signed(b)};
          OP_GE:  r = {31'b0, $signed(a) >= $signed(b)};
          default: begin
            done = 1'b1;
            r    = b;
          end
        endcase
        if (!done) push_value(r);
      end
      FUNC_END: begin
        r    = pop_value();
        done = 1'b1;
      end
      FUNC_INC: if (t.idx < NUM_REGS) calc_regs[t.idx] = calc_regs[t.idx] + 1'b1;
      FUNC_DEC: if (t.idx < NUM_REGS) calc_regs[t.idx] = calc_regs[t.idx] - 1'b1;
      default: ;
    endcase
    if (done) begin
      if (t.store && t.idx < NUM_REGS) calc_regs[t.idx] = r[REG_W-1:0];
      pending_results.push_back('{res_value: r, ovf: calc_ovf, dz: calc_dz});
      calc_depth = 0;
      calc_ovf   = 1'b0;
      calc_dz    = 1'b0;
    end
  endfunction

  function automatic token_t make_token(logic [FUNC_W-1:0] f, logic [LIT_W-1:0] lit,
                                        logic [IDX_W-1:0] idx, logic [OP_W-1:0] op,
                                        logic store);
    return '{func: f, lit: lit, idx: idx, op: op, store: store};
  endfunction

  function automatic logic [LIT_W-1:0] random_literal();
    logic [LIT_W-1:0] lit;
    case ($urandom_range(0, 3))
      0: lit = LIT_W'($urandom_range(0, 16));
      1: lit = LIT_MAX - LIT_W'($urandom_range(0, 3));
      default: lit = LIT_W'($urandom());
    endcase
    return lit;
  endfunction

  // A push with random filler in the fields that the push does not use.
  function automatic token_t random_push();
    token_t t;
    t = make_token(FUNC_PUSH_LIT, random_literal(), IDX_W'($urandom_range(0, 15)),
                   OP_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) == 0) t.func = FUNC_PUSH_REG;
    return t;
  endfunction

  // Sends one request. Valid is left high after acceptance so that
  // back-to-back requests in a burst need no extra assignment.
  task automatic send_token(input token_t t);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid      <= 1'b1;
    func          <= t.func;
    literal_value <= t.lit;
    reg_index     <= t.idx;
    op_code       <= t.op;
    store_result  <= t.store;
    do @(posedge clk); while (in_stall);
    evaluate_token(t);
  endtask

  task automatic test_empty_and_registers();
    send_token(make_token(FUNC_END, 0, 0, OP_ADD, 1'b1));
    send_token(make_token(FUNC_DEC, 0, 15, OP_ADD, 1'b0));
    send_token(make_token(FUNC_INC, 0, 0, OP_ADD, 1'b0));
    send_token(make_token(FUNC_PUSH_REG, 0, 15, OP_ADD, 1'b0));
    send_token(make_token(FUNC_PUSH_REG, 0, 0, OP_ADD, 1'b0));
    send_token(make_token(FUNC_OPER, 0, 0, OP_ADD, 1'b0));
    send_token(make_token(FUNC_END, 0, 14, OP_ADD, 1'b1));
  endtask

  task automatic test_arithmetic_extremes();
    send_token(make_token(FUNC_PUSH_LIT, LIT_MAX, 0, OP_ADD, 1'b0));
    send_token(make_token(FUNC_PUSH_LIT, LIT_MAX, 0, OP_ADD, 1'b0));
    send_token(make_token(FUNC_OPER, 0, 0, OP_MUL, 1'b0));
    send_token(make_token(FUNC_PUSH_LIT, LIT_MAX, 0, OP_ADD, 1'b0));
    send_token(make_token(FUNC_OPER, 0, 0, OP_ADD, 1'b0));
    send_token(make_token(FUNC_PUSH_LIT, 0, 0, OP_ADD, 1'b0));
    send_token(make_token(FUNC_PUSH_LIT, 1, 0, OP_ADD, 1'b0));
    send_token(make_token(FUNC_OPER, 0, 0, OP_SUB, 1'b0));
    // The most negative value over -1 wraps back to itself.
    send_token(make_token(FUNC_OPER, 0, 0, OP_DIV, 1'b0));
    send_token(make_token(FUNC_END, 0, 15, OP_ADD, 1'b1));
    // Zero over zero from an empty stack.
    send_token(make_token(FUNC_OPER, 0, 0, OP_DIV, 1'b0));
    send_token(make_token(FUNC_END, LIT_MAX, 15, OP_UNDEF_HI, 1'b0));
  endtask

  task automatic test_comparisons();
    send_token(make_token(FUNC_OPER, 0, 0, OP_EQ, 1'b0));
    send_token(make_token(FUNC_OPER, 0, 0, OP_NE, 1'b0));
    send_token(make_token(FUNC_OPER, 0, 0, OP_LT, 1'b0));
    send_token(make_token(FUNC_OPER, 0, 0, OP_GT, 1'b0));
    send_token(make_token(FUNC_OPER, 0, 0, OP_LE, 1'b0));
    send_token(make_token(FUNC_OPER, 0, 0, OP_GE, 1'b0));
    send_token(make_token(FUNC_PUSH_LIT, 0, 0, OP_ADD, 1'b0));
    send_token(make_token(FUNC_PUSH_LIT, 1, 0, OP_ADD, 1'b0));
    send_token(make_token(FUNC_OPER, 0, 0, OP_SUB, 1'b0));
    send_token(make_token(FUNC_PUSH_LIT, 1, 0, OP_ADD, 1'b0));
    send_token(make_token(FUNC_OPER, 0, 0, OP_LT, 1'b0));
    send_token(make_token(FUNC_END, 0, 1, OP_ADD, 1'b1));
  endtask

  task automatic test_stack_overflow();
    for (int i = 0; i <= STACK_DEPTH; i++)
      send_token(make_token(FUNC_PUSH_LIT, LIT_W'(i + 1), 0, OP_ADD, 1'b0));
    send_token(make_token(FUNC_END, 0, 3, OP_ADD, 1'b1));
  endtask

  task automatic test_unknown_tokens();
    send_token(make_token(FUNC_PUSH_LIT, 3, 0, OP_ADD, 1'b0));
    send_token(make_token(FUNC_PUSH_LIT, 4, 0, OP_ADD, 1'b0));
    send_token(make_token(FUNC_OPER, 0, 2, OP_UNDEF_HI, 1'b1));
    send_token(make_token(FUNC_PUSH_LIT, 5, 0, OP_ADD, 1'b0));
    send_token(make_token(FUNC_OPER, 0, 4, OP_UNDEF_LO, 1'b0));
    send_token(make_token(FUNC_RSVD_A, LIT_MAX, 15, OP_UNDEF_HI, 1'b1));
    send_token(make_token(FUNC_RSVD_B, 0, 0, OP_ADD, 1'b1));
    send_token(make_token(FUNC_PUSH_REG, 0, 2, OP_ADD, 1'b0));
    send_token(make_token(FUNC_END, 0, 0, OP_ADD, 1'b0));
  endtask

  // Mostly well-formed expressions with random content, laced with register
  // updates, stray tokens and the occasional push onto a full stack.
  task automatic test_random_expressions(input int unsigned budget);
    int unsigned sent, len, pick, op_odds;
    token_t      t;
    sent = 0;
    while (sent < budget) begin
      len = $urandom_range(1, 20);
      repeat (len) begin
        pick    = $urandom_range(0, 99);
        op_odds = (calc_depth >= STACK_DEPTH) ? 88 : 55;
        t       = random_push();
        if (pick < 6) begin
          t.func = FUNC_W'($urandom_range(0, 7));
          t.op   = OP_W'($urandom_range(0, 15));
        end else if (pick < 12) begin
          t.func = ($urandom_range(0, 1) == 0) ? FUNC_INC : FUNC_DEC;
        end else if (calc_depth >= 2 && pick < op_odds) begin
          t.func = FUNC_OPER;
          t.op   = OP_W'($urandom_range(OP_ADD, OP_GE));
        end
        send_token(t);
        if (t.func != FUNC_RSVD_A && t.func != FUNC_RSVD_B) sent++;
      end
      t      = random_push();
      t.func = FUNC_END;
      if ($urandom_range(0, 9) == 0) begin
        t.func = FUNC_OPER;
        t.op   = OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
      end
      send_token(t);
      sent++;
    end
  endtask

  // Result side stall pattern: free-flowing, coin-flip, mostly stalled or
  // mostly free, with a new pattern picked after each random span.
  initial begin
    int unsigned mode, span;
    out_stall <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 1) == 0);
          2: out_stall <= ($urandom_range(0, 7) != 0);
          default: out_stall <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    expr_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no expression pending: value %0d", value);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (value !== want.res_value) begin
          $error("value: expected %0d, got %0d", $signed(want.res_value), value);
          mismatch_count++;
        end
        if (overflow_seen !== want.ovf) begin
          $error("overflow_seen: expected %0b, got %0b", want.ovf, overflow_seen);
          mismatch_count++;
        end
        if (div_zero_seen !== want.dz) begin
          $error("div_zero_seen: expected %0b, got %0b", want.dz, div_zero_seen);
          mismatch_count++;
        end
      end
    end
  end

  // Ends a hung run: counts cycles in which neither side moves a request.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    func          <= FUNC_PUSH_LIT;
    literal_value <= '0;
    reg_index     <= '0;
    op_code       <= OP_ADD;
    store_result  <= 1'b0;
    for (int i = 0; i < NUM_REGS; i++) calc_regs[i] = '0;
    calc_depth     = 0;
    calc_ovf       = 1'b0;
    calc_dz        = 1'b0;
    burst_left     = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_empty_and_registers();
    test_arithmetic_extremes();
    test_comparisons();
    test_stack_overflow();
    test_unknown_tokens();
    test_random_expressions(RANDOM_TOKENS);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rpn_pkg.sv
rtl/rpn_ram.sv
rtl/rpn_div.sv
rtl/rpn_ctrl.sv
rtl/rpn_dpath.sv
rtl/rpn_expression_evaluator.sv
bench/rpn_expression_evaluator_tb.sv
